// ----- hw/rtl/mrw_pkg.sv -----
// Shared Miller-Rabin types: sequencer and multiplier states, multiply codes.
`timescale 1ns / 1ps

package mrw_pkg;

	// top-level sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_AFTER,
		ST_WAIT,
		ST_FINISH
	} seq_state_t;

	// purpose of the modular multiply in flight
	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_POW_SQ,
		OP_POW_MUL,
		OP_TAIL_SQ
	} mul_op_t;

	// shift-add multiplier states
	typedef enum logic [1:0] {
		MM_IDLE,
		MM_DBL,
		MM_ADD
	} mm_state_t;

endpackage

// ----- hw/rtl/mrw_mulmod.sv -----
// Shift-add modular multiplier built around one shared modular adder.
`timescale 1ns / 1ps

module mrw_mulmod #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] product
);
	import mrw_pkg::*;

	localparam int CW = $clog2(W);

	mm_state_t      state_q, state_d;
	logic [W-1:0]   a_q, b_q, m_q, acc_q;
	logic [CW-1:0]  cnt_q;
	logic           done_q;
	logic           fin, shift;
	logic [W-1:0]   y, room, sum;
	logic           ge;

	// shared modular adder: acc + y mod m, both operands below m
	assign y    = (state_q == MM_ADD) ? a_q : acc_q;
	assign room = m_q - y;
	assign ge   = (acc_q >= room);
	assign sum  = ge ? (acc_q - room) : (acc_q + y);

	// walk multiplier bits MSB first: double, then add when the bit is set
	always_comb begin
		state_d = state_q;
		fin     = 1'b0;
		shift   = 1'b0;
		case (state_q)
			MM_IDLE: begin
				if (start) state_d = MM_DBL;
			end
			MM_DBL: begin
				if (b_q[W-1]) begin
					state_d = MM_ADD;
				end else begin
					shift = 1'b1;
					if (cnt_q == '0) begin
						fin     = 1'b1;
						state_d = MM_IDLE;
					end
				end
			end
			MM_ADD: begin
				shift = 1'b1;
				if (cnt_q == '0) begin
					fin     = 1'b1;
					state_d = MM_IDLE;
				end else begin
					state_d = MM_DBL;
				end
			end
			default: state_d = MM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	// capture operands, then accumulate and shift
	always_ff @(posedge clk) begin
		if (state_q == MM_IDLE) begin
			if (start) begin
				a_q   <= a;
				b_q   <= b;
				m_q   <= m;
				acc_q <= '0;
				cnt_q <= CW'(W - 1);
			end
		end else begin
			acc_q <= sum;
			if (shift) begin
				b_q   <= {b_q[W-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- hw/rtl/miller_rabin_witness_test.sv -----
// Top level of the Miller-Rabin witness round: sequencer, operand select and result register.
//
// Usage: present a candidate and a witness base on the input channel (in_valid/in_ready);
// one word comes back on the output channel (out_valid/out_ready) carrying probably_prime.
// Both fields are cut to their low WORD_BITS bits. The block takes one word at a time:
// in_ready is high only while the sequencer is idle.
// Candidates below 2 and even candidates are settled without multiplies. Odd candidates
// run up to 2*WORD_BITS-2 modular multiplies (one reduction of the witness, then squares
// and multiplies over the bits of n-1) on the single shift-add multiplier; each multiply
// walks the multiplier bits MSB first, doubling for every bit and adding for each set bit.
// The result sits in an output register, so a new word is taken while the last result
// waits; if the receiver still stalls when the next result is done, the sequencer holds it.
// Reset clears the sequencer and the output valid; no word is in flight afterwards.
`timescale 1ns / 1ps

module miller_rabin_witness_test #(
	parameter int WORD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] candidate,
	input  logic [63:0] witness,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        probably_prime
);
	import mrw_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int IW = $clog2(WORD_BITS);
	localparam logic [W-1:0] ONE_W = W'(1);
	localparam logic [W-1:0] TWO_W = W'(2);

	seq_state_t     state_q, state_d;
	mul_op_t        op_q, op_d;
	logic           kick_q, kick_d;
	logic           out_valid_q, out_q, load_out;
	logic           verdict_q, verdict_d;
	logic [W-1:0]   n_q, nm1_q, w_q;
	logic [W-1:0]   e_q, e_d, acc_q, acc_d, base_q, base_d, prev_q, prev_d;
	logic [IW-1:0]  idx_q, idx_d, cnt_q, cnt_d;
	logic [W-1:0]   n_in, w_in;
	logic           in_fire, special;
	logic [W-1:0]   mm_a, mm_b, mm_p;
	logic           mm_done;

	assign n_in     = candidate[W-1:0];
	assign w_in     = witness[W-1:0];
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	// even numbers and one are settled without arithmetic
	assign special  = !n_in[0] || (n_in == ONE_W);

	// select multiplier operands for the pending operation
	always_comb begin
		case (op_q)
			OP_REDUCE: begin
				mm_a = ONE_W;
				mm_b = w_q;
			end
			OP_POW_MUL: begin
				mm_a = base_q;
				mm_b = acc_q;
			end
			default: begin
				mm_a = acc_q;
				mm_b = acc_q;
			end
		endcase
	end

	mrw_mulmod #(
		.W(W)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (kick_q),
		.a       (mm_a),
		.b       (mm_b),
		.m       (n_q),
		.done    (mm_done),
		.product (mm_p)
	);

	// sequence: reduce witness, left-to-right power over odd part of n-1, then squaring tail
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		kick_d    = 1'b0;
		load_out  = 1'b0;
		verdict_d = verdict_q;
		e_d       = e_q;
		idx_d     = idx_q;
		acc_d     = acc_q;
		base_d    = base_q;
		prev_d    = prev_q;
		cnt_d     = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (special) begin
						verdict_d = (n_in == TWO_W);
						state_d   = ST_FINISH;
					end else begin
						e_d     = n_in - ONE_W;
						idx_d   = IW'(W - 1);
						kick_d  = 1'b1;
						op_d    = OP_REDUCE;
						state_d = ST_WAIT;
					end
				end
			end
			ST_SCAN: begin
				// skip leading zeros of the exponent
				if (e_q[W-1]) begin
					acc_d   = base_q;
					state_d = ST_AFTER;
				end else begin
					e_d   = {e_q[W-2:0], 1'b0};
					idx_d = idx_q - IW'(1);
				end
			end
			ST_AFTER: begin
				if (e_q[W-2:0] == '0) begin
					// odd part done; remaining bits are the squaring tail
					if (idx_q == '0) begin
						verdict_d = (acc_q == ONE_W);
						state_d   = ST_FINISH;
					end else begin
						cnt_d   = idx_q;
						prev_d  = acc_q;
						kick_d  = 1'b1;
						op_d    = OP_TAIL_SQ;
						state_d = ST_WAIT;
					end
				end else begin
					e_d     = {e_q[W-2:0], 1'b0};
					idx_d   = idx_q - IW'(1);
					kick_d  = 1'b1;
					op_d    = OP_POW_SQ;
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (mm_done) begin
					case (op_q)
						OP_REDUCE: begin
							base_d  = mm_p;
							state_d = ST_SCAN;
						end
						OP_POW_SQ: begin
							acc_d = mm_p;
							if (e_q[W-1]) begin
								kick_d = 1'b1;
								op_d   = OP_POW_MUL;
							end else begin
								state_d = ST_AFTER;
							end
						end
						OP_POW_MUL: begin
							acc_d   = mm_p;
							state_d = ST_AFTER;
						end
						OP_TAIL_SQ: begin
							acc_d  = mm_p;
							prev_d = mm_p;
							// a nontrivial square root of one marks a composite
							if (mm_p == ONE_W && prev_q != ONE_W && prev_q != nm1_q) begin
								verdict_d = 1'b0;
								state_d   = ST_FINISH;
							end else if (cnt_q == IW'(1)) begin
								verdict_d = (mm_p == ONE_W);
								state_d   = ST_FINISH;
							end else begin
								cnt_d  = cnt_q - IW'(1);
								kick_d = 1'b1;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_REDUCE;
			kick_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			kick_q  <= kick_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			n_q   <= n_in;
			nm1_q <= n_in - ONE_W;
			w_q   <= w_in;
		end
		e_q       <= e_d;
		idx_q     <= idx_d;
		acc_q     <= acc_d;
		base_q    <= base_d;
		prev_q    <= prev_d;
		cnt_q     <= cnt_d;
		verdict_q <= verdict_d;
		if (load_out) begin
			out_q <= verdict_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign probably_prime = out_q;

	// a multiply is launched only while the sequencer waits for it
	a_kick_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		kick_q |-> (state_q == ST_WAIT))
		else $error("multiply launched outside wait state");

	// the multiplier finishes only for a multiply that is already running
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_WAIT && !kick_q))
		else $error("multiply done with no multiply pending");

	// an odd candidate above one always leaves a set bit in n-1
	a_scan_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (e_q != '0))
		else $error("exponent scan on an empty exponent");

	// a finished verdict lands in the output register and frees the input
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && (!out_valid_q || out_ready)) |=>
		(out_valid_q && state_q == ST_IDLE))
		else $error("verdict not delivered to output register");

	// an accepted word starts work at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("accepted word left sequencer idle");

endmodule

// ----- tb/tb_miller_rabin_witness_test.sv -----
// Testbench for the Miller-Rabin witness round: directed, back-pressure and random words.
`timescale 1ns / 1ps

module tb_miller_rabin_witness_test;

	localparam int          WORD_BITS = 64;
	localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - WORD_BITS);
	localparam logic [63:0] ALL_ONES  = {64{1'b1}};

	typedef struct packed {
		logic [63:0] cand;
		logic [63:0] wit;
		logic        verdict;
	} round_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] candidate = '0;
	logic [63:0] witness = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        probably_prime;

	round_t pending_rounds[$];
	int     error_count = 0;
	int     rounds_sent = 0;
	int     verdicts_seen = 0;
	int     prime_verdicts = 0;
	int     input_stall_cycles = 0;
	int     hold_request = 0;
	bit     steady = 1'b0;

	miller_rabin_witness_test #(
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.candidate     (candidate),
		.witness       (witness),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.probably_prime(probably_prime)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// exact modular product through a double-width intermediate
	function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] wide;
		wide = {64'd0, a} * {64'd0, b};
		wide = wide % {64'd0, m};
		return wide[63:0];
	endfunction

	// square-and-multiply, m >= 3
	function automatic logic [63:0] mod_power(logic [63:0] base, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1;
		sq  = base % m;
		while (e != 0) begin
			if (e[0])
				acc = mod_product(acc, sq, m);
			sq = mod_product(sq, sq, m);
			e  = e >> 1;
		end
		return acc;
	endfunction

	// verdict of one witness round on the masked inputs
	function automatic logic passes_witness_round(logic [63:0] cand_in, logic [63:0] wit_in);
		logic [63:0] n;
		logic [63:0] w;
		logic [63:0] odd_part;
		logic [63:0] x;
		logic [63:0] prev;
		int          twos;
		n = cand_in & WORD_MASK;
		w = wit_in & WORD_MASK;
		if (n < 2)
			return 1'b0;
		if (n == 2)
			return 1'b1;
		if (!n[0])
			return 1'b0;
		odd_part = n - 1;
		twos = 0;
		while (!odd_part[0]) begin
			odd_part = odd_part >> 1;
			twos++;
		end
		x = mod_power(w, odd_part, n);
		prev = x;
		for (int i = 0; i < twos; i++) begin
			x = mod_product(x, x, n);
			// a square of 1 from a root other than +-1 exposes a composite
			if (x == 1 && prev != 1 && prev != n - 1)
				return 1'b0;
			prev = x;
		end
		return x == 1;
	endfunction

	function automatic logic [63:0] known_prime(int k);
		case (k)
			0:       return 64'd3;
			1:       return 64'd65537;
			2:       return 64'd2147483647;
			3:       return 64'd998244353;
			4:       return 64'd1000000007;
			5:       return 64'd4294967291;
			6:       return 64'h1FFF_FFFF_FFFF_FFFF;
			7:       return 64'hFFFF_FFFF_0000_0001;
			default: return 64'hFFFF_FFFF_FFFF_FFC5;
		endcase
	endfunction

	// strong pseudoprimes to small bases, plus one Carmichael number
	function automatic logic [63:0] known_pseudoprime(int k);
		case (k)
			0:       return 64'd2047;
			1:       return 64'd1373653;
			2:       return 64'd25326001;
			3:       return 64'd3215031751;
			4:       return 64'd3825123056546413051;
			5:       return 64'd561;
			default: return 64'd4759123141;
		endcase
	endfunction

	function automatic logic [63:0] small_prime(int k);
		case (k)
			0:       return 64'd2;
			1:       return 64'd3;
			2:       return 64'd5;
			3:       return 64'd7;
			4:       return 64'd11;
			5:       return 64'd13;
			6:       return 64'd17;
			7:       return 64'd19;
			8:       return 64'd23;
			default: return 64'd61;
		endcase
	endfunction

	// mostly short gaps, a few long ones, none in a steady stretch
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// offer one word and hold it until taken; called at a rising edge
	task automatic send_word(input logic [63:0] c, input logic [63:0] w);
		int     gap;
		round_t r;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		candidate <= c;
		witness   <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r.cand    = c;
		r.wit     = w;
		r.verdict = passes_witness_round(c, w);
		pending_rounds.push_back(r);
		rounds_sent++;
	endtask

	// candidates settled without any modular work, then the odd all-ones word
	task automatic test_early_decisions();
		send_word(64'd0, {$urandom, $urandom});
		send_word(64'd1, {$urandom, $urandom});
		send_word(64'd2, 64'd0);
		send_word(64'd2, ALL_ONES);
		send_word(64'd4, 64'd3);
		send_word(ALL_ONES - 64'd1, 64'd5);
		send_word(ALL_ONES, 64'd2);
	endtask

	// zero, trivial and fooling bases, nontrivial square roots of one
	task automatic test_special_witnesses();
		logic [63:0] m61;
		m61 = known_prime(6);
		send_word(m61, 64'd0);
		send_word(m61, m61);
		send_word(m61, 64'd1);
		send_word(m61, m61 - 64'd1);
		send_word(m61, ALL_ONES);
		send_word(known_prime(8), 64'd2);
		send_word(64'd561, 64'd2);
		send_word(64'd561, 64'd560);
		send_word(64'd2047, 64'd2);
		send_word(64'd3215031751, 64'd7);
		send_word(64'd3825123056546413051, 64'd23);
		send_word(64'd3, 64'd2);
		send_word(64'd9, 64'd8);
	endtask

	// hold the output side long enough that the block fills and stalls its input
	task automatic test_output_holdoff();
		hold_request = 30000;
		send_word(64'd6, 64'd5);
		send_word(64'd1, 64'd1);
		send_word(64'd2, 64'd7);
		send_word(known_prime(4), {$urandom, $urandom});
		send_word(64'd561, 64'd5);
		send_word({$urandom, $urandom} | 64'd1, {$urandom, $urandom});
	endtask

	// mostly odd candidates with structure, the rest noise
	task automatic test_random_rounds(input int count);
		int          sel;
		logic [63:0] n;
		logic [63:0] w;
		for (int k = 0; k < count; k++) begin
			steady = (k >= count / 3 && k < count / 2);
			sel = $urandom_range(0, 99);
			w = {$urandom, $urandom};
			if (sel < 30) begin
				n = known_prime($urandom_range(0, 8));
			end else if (sel < 45) begin
				n = known_pseudoprime($urandom_range(0, 6));
				if ($urandom_range(0, 1) == 1)
					w = small_prime($urandom_range(0, 9));
			end else if (sel < 55) begin
				n = (sel < 50) ? known_prime($urandom_range(0, 8)) : ({$urandom, $urandom} | 64'd1);
				case ($urandom_range(0, 3))
					0:       w = 64'd0;
					1:       w = 64'd1;
					2:       w = n - 64'd1;
					default: w = n[63] ? n : n << 1;
				endcase
			end else if (sel < 80) begin
				n = {$urandom, $urandom} | 64'd1;
			end else if (sel < 90) begin
				n = 64'($urandom_range(3, 65535)) | 64'd1;
			end else begin
				case ($urandom_range(0, 3))
					0:       n = {$urandom, $urandom} & ~64'd1;
					1:       n = 64'($urandom_range(0, 2));
					default: n = {$urandom, $urandom};
				endcase
			end
			send_word(n, w);
		end
		steady = 1'b0;
	endtask

	// output side: check each accepted word, then pick ready for the next cycle
	initial begin : result_side
		int     stall_left;
		int     hold_left;
		round_t exp_round;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (in_valid && !in_ready)
					input_stall_cycles++;
				if (out_valid && out_ready) begin
					verdicts_seen++;
					if (pending_rounds.size() == 0) begin
						report_mismatch($sformatf("verdict %b with no word outstanding",
							probably_prime));
					end else begin
						exp_round = pending_rounds.pop_front();
						if (probably_prime !== exp_round.verdict)
							report_mismatch($sformatf("n=%0d a=%0d: probably_prime %b, want %b",
								exp_round.cand, exp_round.wit, probably_prime,
								exp_round.verdict));
						else if (exp_round.verdict)
							prime_verdicts++;
					end
				end
			end
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				stall_left = idle_cycles();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int     waited;
		round_t left;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_early_decisions();
		test_special_witnesses();
		test_output_holdoff();
		test_random_rounds(100);
		in_valid <= 1'b0;

		// drain: wait for every verdict, then watch for strays
		waited = 0;
		while (pending_rounds.size() != 0 && waited < 40000) begin
			@(posedge clk);
			waited++;
		end
		repeat (64) @(posedge clk);
		while (pending_rounds.size() != 0) begin
			left = pending_rounds.pop_front();
			report_mismatch($sformatf("no verdict for n=%0d a=%0d", left.cand, left.wit));
		end

		$display("Checked %0d of %0d rounds: %0d probably prime, rest composite or trivially rejected",
			verdicts_seen, rounds_sent, prime_verdicts);
		$display("Input side held back %0d cycles; mix of tiny, even, pseudoprime and 64-bit primes",
			input_stall_cycles);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#100000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- miller_rabin_witness_test.f -----
hw/rtl/mrw_pkg.sv
hw/rtl/mrw_mulmod.sv
hw/rtl/miller_rabin_witness_test.sv
tb/tb_miller_rabin_witness_test.sv
